// ===== design/tcfps_pkg.sv =====
package tcfps_pkg;

    localparam int FREQ_W     = 23;
    localparam int LEVEL_W    = 12;
    localparam int NUM_LANES  = 5;
    localparam int SUM_W      = 15;
    localparam int AVG_W      = 12;
    localparam int BEST_W     = 16;
    localparam int SYNTH_W    = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - FREQ_W - SYNTH_W;

    localparam logic [FREQ_W:0]   COARSE_STEP  = 24'd1000;
    localparam logic [FREQ_W:0]   FINE_STEP    = 24'd125;
    localparam logic [FREQ_W:0]   FINE_SPAN    = 24'd5000;
    localparam logic [FREQ_W:0]   SYNTH_OFFSET = 24'd480000;
    localparam logic [FREQ_W-1:0] FREQ_MAX     = 23'h7FFFFF;
    localparam logic [BEST_W-1:0] LEVEL_INIT_MIN = 16'hFFFF;

    // sum / 5 as (sum * ceil(2^17 / 5)) >> 17, exact for sum < 2^15
    localparam int               AVG_SHIFT = 17;
    localparam logic [SUM_W-1:0] AVG_RECIP = 15'd26215;

    // x / 125 as (x * ceil(2^31 / 125)) >> 31, exact for x < 2^24
    localparam int          SYNTH_SHIFT = 31;
    localparam int          SYNTH_RW    = 25;
    localparam logic [SYNTH_RW-1:0] SYNTH_RECIP = 25'd17179870;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_FREQ = 2'd0,
        REG_END_FREQ   = 2'd1,
        REG_MODE       = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [FREQ_W-1:0] start_freq;
        logic [FREQ_W-1:0] end_freq;
        logic              higher;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] command;
        logic             locked;
        logic [AVG_W-1:0] avg;
    } avg_item_t;

    typedef struct packed {
        logic              valid;
        logic [FREQ_W-1:0] tune_freq;
        logic              still_scanning;
    } tune_t;

endpackage

// ===== design/tcfps_lanes.sv =====
module tcfps_lanes
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         en,
    input  logic                                         in_valid,
    input  logic [tcfps_pkg::CMD_W-1:0]                  in_command,
    input  logic                                         in_locked,
    input  logic [tcfps_pkg::NUM_LANES*tcfps_pkg::LEVEL_W-1:0] in_levels,
    output tcfps_pkg::avg_item_t                         avg_item
);

    logic [tcfps_pkg::LEVEL_W-1:0] lane_reg [tcfps_pkg::NUM_LANES];
    logic                          s1_valid_reg;
    logic [tcfps_pkg::CMD_W-1:0]   s1_cmd_reg;
    logic                          s1_lock_reg;

    logic [tcfps_pkg::SUM_W-1:0]   sum_next;
    logic [tcfps_pkg::SUM_W-1:0]   sum_reg;
    logic                          s2_valid_reg;
    logic [tcfps_pkg::CMD_W-1:0]   s2_cmd_reg;
    logic                          s2_lock_reg;

    logic [2*tcfps_pkg::SUM_W-1:0] avg_prod;
    tcfps_pkg::avg_item_t          avg_reg;

    // one register per reading
    for (genvar i = 0; i < tcfps_pkg::NUM_LANES; i++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (en)
                lane_reg[i] <= in_levels[i*tcfps_pkg::LEVEL_W +: tcfps_pkg::LEVEL_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            avg_reg      <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            avg_reg      <= '{valid:   s2_valid_reg,
                              command: s2_cmd_reg,
                              locked:  s2_lock_reg,
                              avg:     avg_prod[tcfps_pkg::AVG_SHIFT +: tcfps_pkg::AVG_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg  <= in_command;
            s1_lock_reg <= in_locked;
            s2_cmd_reg  <= s1_cmd_reg;
            s2_lock_reg <= s1_lock_reg;
            sum_reg     <= sum_next;
        end
    end

    // merge: lane sum
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < tcfps_pkg::NUM_LANES; i++)
            sum_next = sum_next + tcfps_pkg::SUM_W'(lane_reg[i]);
    end

    assign avg_prod = {{tcfps_pkg::SUM_W{1'b0}}, sum_reg}
                    * {{tcfps_pkg::SUM_W{1'b0}}, tcfps_pkg::AVG_RECIP};

    assign avg_item = avg_reg;

endmodule

// ===== design/tcfps_seq.sv =====
module tcfps_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  tcfps_pkg::avg_item_t avg_item,
    input  tcfps_pkg::cfg_t      cfg,
    output tcfps_pkg::tune_t     res
);

    logic                           active_reg,     active_next;
    logic                           fine_reg,       fine_next;
    logic [tcfps_pkg::FREQ_W-1:0]   sweep_reg,      sweep_next;
    logic [tcfps_pkg::BEST_W-1:0]   best_level_reg, best_level_next;
    logic [tcfps_pkg::FREQ_W-1:0]   best_freq_reg,  best_freq_next;
    logic [tcfps_pkg::FREQ_W-1:0]   coarse_reg,     coarse_next;
    tcfps_pkg::tune_t               res_reg,        res_next;

    logic [tcfps_pkg::BEST_W-1:0]   level_init;
    logic [tcfps_pkg::BEST_W-1:0]   avg_ext;
    logic                           better;
    logic [tcfps_pkg::FREQ_W-1:0]   cand_freq;
    logic [tcfps_pkg::FREQ_W:0]     step_sum;
    logic [tcfps_pkg::FREQ_W:0]     fine_limit;
    logic [tcfps_pkg::FREQ_W:0]     fine_diff;
    logic [tcfps_pkg::FREQ_W-1:0]   fine_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            fine_reg       <= 1'b0;
            sweep_reg      <= '0;
            best_level_reg <= '0;
            best_freq_reg  <= '0;
            coarse_reg     <= '0;
            res_reg        <= '0;
        end
        else if (en)
        begin
            active_reg     <= active_next;
            fine_reg       <= fine_next;
            sweep_reg      <= sweep_next;
            best_level_reg <= best_level_next;
            best_freq_reg  <= best_freq_next;
            coarse_reg     <= coarse_next;
            res_reg        <= res_next;
        end
    end

    assign level_init = cfg.higher ? '0 : tcfps_pkg::LEVEL_INIT_MIN;
    assign avg_ext    = tcfps_pkg::BEST_W'(avg_item.avg);
    assign better     = cfg.higher ? (avg_ext > best_level_reg) : (avg_ext < best_level_reg);
    assign cand_freq  = better ? sweep_reg : best_freq_reg;
    assign step_sum   = {1'b0, sweep_reg}
                      + (fine_reg ? tcfps_pkg::FINE_STEP : tcfps_pkg::COARSE_STEP);
    assign fine_limit = {1'b0, coarse_reg} + tcfps_pkg::FINE_SPAN;
    assign fine_diff  = {1'b0, cand_freq} - tcfps_pkg::FINE_SPAN;
    assign fine_start = ({1'b0, cand_freq} >= tcfps_pkg::FINE_SPAN)
                      ? fine_diff[tcfps_pkg::FREQ_W-1:0] : '0;

    always_comb
    begin
        active_next     = active_reg;
        fine_next       = fine_reg;
        sweep_next      = sweep_reg;
        best_level_next = best_level_reg;
        best_freq_next  = best_freq_reg;
        coarse_next     = coarse_reg;
        res_next        = '0;

        if (avg_item.valid)
        begin
            unique case (tcfps_pkg::cmd_t'(avg_item.command))
                tcfps_pkg::CMD_START:
                begin
                    best_level_next = level_init;
                    best_freq_next  = cfg.start_freq;
                    sweep_next      = cfg.start_freq;
                    active_next     = 1'b1;
                    fine_next       = 1'b0;
                    res_next        = '{valid: 1'b1, tune_freq: cfg.start_freq,
                                        still_scanning: 1'b1};
                end
                tcfps_pkg::CMD_STOP:
                begin
                    active_next = 1'b0;
                end
                tcfps_pkg::CMD_SAMPLE:
                begin
                    if (active_reg && avg_item.locked)
                    begin
                        best_level_next = better ? avg_ext : best_level_reg;
                        best_freq_next  = cand_freq;
                        sweep_next      = step_sum[tcfps_pkg::FREQ_W-1:0];
                        if (!fine_reg)
                        begin
                            if (step_sum > {1'b0, cfg.end_freq} || step_sum[tcfps_pkg::FREQ_W])
                            begin
                                fine_next       = 1'b1;
                                sweep_next      = fine_start;
                                coarse_next     = cand_freq;
                                best_level_next = level_init;
                            end
                        end
                        else if (step_sum > fine_limit || step_sum[tcfps_pkg::FREQ_W])
                        begin
                            active_next = 1'b0;
                            sweep_next  = cand_freq;
                        end
                        res_next = '{valid: 1'b1, tune_freq: sweep_next,
                                     still_scanning: active_next};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res = res_reg;

    a_final_tune_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.valid && !res_reg.still_scanning) |-> !active_reg)
        else $error("final tune while scan still active");

    a_scan_tune_active: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.valid && res_reg.still_scanning) |-> active_reg)
        else $error("scanning tune while scan inactive");

    a_tune_is_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.valid |-> (res_reg.tune_freq == sweep_reg))
        else $error("tuned frequency differs from sweep position");

endmodule

// ===== design/tcfps_out.sv =====
module tcfps_out
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcfps_pkg::tune_t                    res,
    output logic                                en,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tcfps_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                m_tuser
);

    logic                                x_valid_reg;
    logic [tcfps_pkg::FREQ_W-1:0]        x_freq_reg;
    logic                                x_scan_reg;
    logic [tcfps_pkg::FREQ_W:0]          x_sum_reg;

    logic [2*tcfps_pkg::SYNTH_RW-2:0]    synth_prod;
    logic [tcfps_pkg::SYNTH_W-1:0]       synth_word;

    logic                                out_valid_reg;
    logic [tcfps_pkg::FREQ_W-1:0]        out_freq_reg;
    logic [tcfps_pkg::SYNTH_W-1:0]       out_word_reg;
    logic                                out_scan_reg;

    logic                                skid_valid_reg;
    logic [tcfps_pkg::FREQ_W-1:0]        skid_freq_reg;
    logic [tcfps_pkg::SYNTH_W-1:0]       skid_word_reg;
    logic                                skid_scan_reg;

    logic                                push;
    logic                                pop;

    assign en   = !skid_valid_reg;
    assign push = en && x_valid_reg;
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x_valid_reg <= 1'b0;
        else if (en)
            x_valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_freq_reg <= res.tune_freq;
            x_scan_reg <= res.still_scanning;
            x_sum_reg  <= {1'b0, res.tune_freq} + tcfps_pkg::SYNTH_OFFSET;
        end
    end

    assign synth_prod = {{(tcfps_pkg::SYNTH_RW-1){1'b0}}, x_sum_reg}
                      * {{(tcfps_pkg::SYNTH_RW-2){1'b0}}, tcfps_pkg::SYNTH_RECIP};
    assign synth_word = synth_prod[tcfps_pkg::SYNTH_SHIFT +: tcfps_pkg::SYNTH_W];

    // output register plus skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_freq_reg <= skid_freq_reg;
                out_word_reg <= skid_word_reg;
                out_scan_reg <= skid_scan_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_freq_reg <= x_freq_reg;
                out_word_reg <= synth_word;
                out_scan_reg <= x_scan_reg;
            end
            else
            begin
                skid_freq_reg <= x_freq_reg;
                skid_word_reg <= synth_word;
                skid_scan_reg <= x_scan_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{tcfps_pkg::OUT_PAD_W{1'b0}}, out_word_reg, out_freq_reg};
    assign m_tuser  = out_scan_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with output register empty");

    a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("skid entry lost while receiver stalls");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && m_tready && !skid_valid_reg && !x_valid_reg) |=> !out_valid_reg)
        else $error("output still valid after last transfer");

endmodule

// ===== design/tuner_coarse_fine_peak_scan.sv =====
// Coarse/fine peak scan sequencer for a receiver tuner.
// Slave stream: one item per transfer. s_tuser = {tuner_locked, command[1:0]};
// command 0 sample, 1 start scan, 2 stop scan. s_tdata carries the five level
// readings. A start transfer tunes to the start frequency; each locked sample
// during a scan averages the readings, tracks the best level and retunes.
// Master stream: one transfer per retune, carrying the frequency, the
// synthesiser word and the still-scanning flag in m_tuser. Stop and ignored
// samples give no transfer.
// Throughput: one item per cycle while s_tready is high. Pipeline registers in
// order: lane input, lane sum, divide by five, sequencer, synthesiser offset,
// output register.
// Config: cfg_we writes cfg_data into register cfg_index (0 start, 1 end,
// 2 mode); write only while the block is idle.
// Reset: all scan state and the pipeline valid flags clear; registers return
// to start 0, end 8388607, max-level mode. s_tready is high out of reset.
// Stall: an output register and a skid stage hold up to two results; input
// keeps being accepted until the skid stage fills, then s_tready drops.
module tuner_coarse_fine_peak_scan
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // level_a, level_b, level_c, level_d, level_e (12 bits each), zero pad
    input  logic [tcfps_pkg::IN_DATA_W-1:0]     s_tdata,
    // command (2), tuner_locked (1)
    input  logic [tcfps_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tune_freq (23), synth_word (16), zero pad
    output logic [tcfps_pkg::OUT_DATA_W-1:0]    m_tdata,
    // still_scanning (1)
    output logic                                m_tuser,
    input  logic                                cfg_we,
    input  logic [tcfps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcfps_pkg::FREQ_W-1:0]        cfg_data
);

    tcfps_pkg::cfg_t      cfg_reg;
    tcfps_pkg::avg_item_t avg_item;
    tcfps_pkg::tune_t     res;
    logic                 en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_freq <= '0;
            cfg_reg.end_freq   <= tcfps_pkg::FREQ_MAX;
            cfg_reg.higher     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (tcfps_pkg::reg_idx_t'(cfg_index))
                tcfps_pkg::REG_START_FREQ: cfg_reg.start_freq <= cfg_data;
                tcfps_pkg::REG_END_FREQ:   cfg_reg.end_freq   <= cfg_data;
                tcfps_pkg::REG_MODE:       cfg_reg.higher     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = en;

    tcfps_lanes u_lanes
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_command (s_tuser[tcfps_pkg::CMD_W-1:0]),
        .in_locked  (s_tuser[tcfps_pkg::CMD_W]),
        .in_levels  (s_tdata[tcfps_pkg::NUM_LANES*tcfps_pkg::LEVEL_W-1:0]),
        .avg_item   (avg_item)
    );

    tcfps_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .avg_item (avg_item),
        .cfg      (cfg_reg),
        .res      (res)
    );

    tcfps_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
